// ===== sv/bba_pkg.sv =====
// Shared types, constants and a helper function for the bitmap block allocator.
package bba_pkg;

  localparam int unsigned WORD_BITS = 16;
  localparam logic [WORD_BITS-1:0] WORD_FULL = 16'hFFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic req_load;  // latch request, start first read
    logic scan_inc;  // advance to next bitmap word and read it
    logic wr_en;     // write back the updated bitmap word
    logic out_load;  // load the result register
    logic out_full;  // result is an arena-full report
  } bba_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic word_full;  // current bitmap word has no clear bit
    logic scan_last;  // current word is the last one of the map
    logic out_busy;   // result register holds an item that is stalled
  } bba_sts_t;

  // Position of the lowest clear bit of a bitmap word
  function automatic logic [3:0] lowest_clear(input logic [WORD_BITS-1:0] word);
    logic [3:0] pos;
    pos = 4'd0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        pos = 4'(b);
      end
    end
    return pos;
  endfunction

endpackage

// ===== sv/bba_ctrl.sv =====
// Sequencing state machine for the bitmap block allocator.
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  input  bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_ctl_t ctl
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a new item only between requests
  assign in_stall = (state_r != ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.req_load = 1'b1;
          state_nxt    = (in_cmd == CMD_FREE) ? ST_FREE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.word_full) begin
          if (!sts.out_busy) begin
            ctl.wr_en    = 1'b1;
            ctl.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (sts.scan_last) begin
          if (!sts.out_busy) begin
            ctl.out_load = 1'b1;
            ctl.out_full = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      ST_FREE: begin
        if (!sts.out_busy) begin
          ctl.wr_en    = 1'b1;
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/bba_dpath.sv =====
// Bitmap memory, word scan address and result register of the block allocator.
module bba_dpath #(
  parameter int MAP_WORDS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_cmd,
  input  logic [7:0]        in_free_index,
  input  bba_pkg::bba_ctl_t ctl,
  output bba_pkg::bba_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [7:0]        out_granted_index
);
  import bba_pkg::*;

  localparam int WA_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int ARENA = MAP_WORDS * WORD_BITS;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;

  logic [WA_W-1:0]      addr_r;
  logic                 mode_r;
  logic                 free_ok_r;
  logic [3:0]           bit_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvld_r;

  logic                 out_valid_r;
  logic                 out_status_r;
  logic [7:0]           out_index_r;

  logic                 in_range;
  logic [WA_W+3:0]      idx_ext;
  logic [WA_W-1:0]      load_addr;
  logic [WA_W-1:0]      next_addr;
  logic [WA_W-1:0]      rd_addr;
  logic                 rd_en;
  logic [WORD_BITS-1:0] cur_word;
  logic [3:0]           clr_pos;
  logic [3:0]           wr_pos;
  logic [WORD_BITS-1:0] wr_mask;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;
  logic [WA_W+11:0]     blk_ext;

  // Locate the word addressed by a free request
  assign in_range  = (32'(in_free_index) < 32'(ARENA));
  assign idx_ext   = {{WA_W{1'b0}}, in_free_index[7:4]};
  assign load_addr = (in_cmd == CMD_FREE && in_range) ? idx_ext[WA_W-1:0] : '0;
  assign next_addr = WA_W'(addr_r + 1'b1);
  assign rd_addr   = ctl.req_load ? load_addr : next_addr;
  assign rd_en     = ctl.req_load | ctl.scan_inc;

  // Words never written since reset read as all free
  assign cur_word = rvld_r ? rdata_r : '0;
  assign clr_pos  = lowest_clear(cur_word);

  // Set the granted bit or clear the freed one
  assign wr_pos  = (mode_r == CMD_FREE) ? bit_r : clr_pos;
  assign wr_mask = WORD_BITS'(1) << wr_pos;
  assign wr_data = (mode_r == CMD_FREE) ? (cur_word & ~wr_mask) : (cur_word | wr_mask);
  assign wr_en   = ctl.wr_en & ((mode_r != CMD_FREE) | free_ok_r);

  // Block index from word address and bit position
  assign blk_ext = {8'd0, addr_r, clr_pos};

  assign sts.word_full = (cur_word == WORD_FULL);
  assign sts.scan_last = (addr_r == WA_W'(MAP_WORDS - 1));
  assign sts.out_busy  = out_valid_r & out_stall;

  // Latch the request and step the scan address
  always_ff @(posedge clk) begin
    if (ctl.req_load) begin
      addr_r    <= load_addr;
      mode_r    <= in_cmd;
      free_ok_r <= in_range;
      bit_r     <= in_free_index[3:0];
    end else if (ctl.scan_inc) begin
      addr_r <= next_addr;
    end
  end

  // Bitmap memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Track which words hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  // Result register: load a finished item, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= ctl.out_full ? STATUS_FULL : STATUS_OK;
      out_index_r  <= (ctl.out_full || mode_r == CMD_FREE) ? 8'd0 : blk_ext[7:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_index_r;

endmodule

// ===== sv/bitmap_block_allocator_top.sv =====
// Bitmap first-fit block allocator: one allocate or free request per item.
//
// Input channel (in_valid/in_stall): in_cmd selects allocate or free,
// in_free_index names the block to free. Output channel (out_valid/out_stall)
// returns exactly one item per request: out_status (ok or full) and
// out_granted_index (granted block, zero on free or full).
// A request is taken only while no earlier request is in progress; a
// finished result waits in the output register while the next request runs.
// Timing: the bitmap sits in a memory with one registered read port, and an
// allocate reads one bitmap word per cycle in order from word zero.
//   free:     the addressed word is read, then written back as the result loads.
//   allocate: the scan stops at the first word with a clear bit, or at the
//             last word with an arena-full result.
// Reset (rst_n low, synchronous) marks every block free at once through
// per-word valid bits; no clearing pass is needed.
// A stalled receiver holds the result register; a request that finishes
// meanwhile waits in place with its read data held until the slot frees.
module bitmap_block_allocator_top #(
  parameter int BLOCK_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_free_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_status,
  output logic [7:0] out_granted_index
);
  import bba_pkg::*;

  localparam int MAP_WORDS = BLOCK_COUNT / WORD_BITS;

  bba_ctl_t ctl;
  bba_sts_t sts;

  // Sequence requests
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Hold the bitmap and produce results
  bba_dpath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_free_index     (in_free_index),
    .ctl               (ctl),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index)
  );

endmodule
